/* src/itf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the interval tagged-float codec.
// Used by the binary64 adder and the top level; depends on nothing.
package itf_pkg;

	localparam int FRAC_BITS = 52;
	localparam int EXP_BIAS  = 1023;
	localparam int PW        = 14;   // width of the signed search position p
	localparam int EW        = 16;   // width of signed exponent arithmetic

	localparam logic [63:0] MANT_MASK    = 64'h000F_FFFF_FFFF_FFFF;
	localparam logic [63:0] SE_MASK      = 64'hFFF0_0000_0000_0000;
	localparam logic [63:0] MAG_MASK     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] POS_INF_BITS = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] QNAN_BITS    = 64'h7FF8_0000_0000_0000;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;

	localparam logic FUNC_ENC = 1'b0;
	localparam logic FUNC_DEC = 1'b1;

endpackage

/* src/itf_fadd.sv */
`timescale 1ns / 1ps
// Multi-cycle binary64 adder, round to nearest even, with subnormals.
// Uses itf_pkg; normalises up to eight bit positions per cycle.
module itf_fadd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] sum
);

	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_NORM = 2'd1;
	localparam logic [1:0] A_RND  = 2'd2;

	logic [1:0]  state_q;
	logic [56:0] x_q;
	logic [11:0] e_q;
	logic        sign_q;
	logic        done_q;
	logic [63:0] sum_q;

	// Front end: specials, swap, alignment and the wide add.
	logic        a_big;
	logic [63:0] hi, lo;
	logic        nan_a, nan_b, inf_a, inf_b;
	logic [10:0] xe_hi, xe_lo, d;
	logic [55:0] m_hi, m_lo, m_sh;
	logic        stk;
	logic [56:0] x_raw;
	logic        special;
	logic [63:0] special_res;

	always_comb begin
		a_big = a[62:0] >= b[62:0];
		hi = a_big ? a : b;
		lo = a_big ? b : a;
		nan_a = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
		nan_b = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
		inf_a = (a[62:52] == 11'h7FF) && (a[51:0] == '0);
		inf_b = (b[62:52] == 11'h7FF) && (b[51:0] == '0);
		special = nan_a | nan_b | inf_a | inf_b;
		if (nan_a || nan_b || (inf_a && inf_b && (a[63] != b[63])))
			special_res = itf_pkg::QNAN_BITS;
		else if (inf_a)
			special_res = a;
		else
			special_res = b;
		xe_hi = (hi[62:52] == '0) ? 11'd1 : hi[62:52];
		xe_lo = (lo[62:52] == '0) ? 11'd1 : lo[62:52];
		d = xe_hi - xe_lo;
		m_hi = {(hi[62:52] != '0), hi[51:0], 3'b000};
		m_lo = {(lo[62:52] != '0), lo[51:0], 3'b000};
		if (d >= 11'd56) begin
			m_sh = '0;
			stk = |m_lo;
		end else begin
			m_sh = m_lo >> d[5:0];
			stk = |(m_lo & ((56'd1 << d[5:0]) - 56'd1));
		end
		m_sh[0] = m_sh[0] | stk;
		if (hi[63] ^ lo[63])
			x_raw = {1'b0, m_hi} - {1'b0, m_sh};
		else
			x_raw = {1'b0, m_hi} + {1'b0, m_sh};
	end

	// Normalisation step: leading zeros of the top byte, capped by the exponent.
	logic [3:0]  lz;
	logic [11:0] lim;
	logic [3:0]  k;

	always_comb begin
		lz = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (x_q[48 + i])
				lz = 4'(7 - i);
		end
		lim = e_q - 12'd1;
		k = (lim < {8'd0, lz}) ? lim[3:0] : lz;
	end

	// Rounding.
	logic        up;
	logic [53:0] m_r;
	logic [11:0] fld;
	logic [51:0] man;
	logic [63:0] rnd_res;

	always_comb begin
		up = x_q[2] & (x_q[1] | x_q[0] | x_q[3]);
		m_r = {1'b0, x_q[55:3]} + {53'd0, up};
		if (m_r[53]) begin
			fld = e_q + 12'd1;
			man = m_r[52:1];
		end else begin
			fld = m_r[52] ? e_q : 12'd0;
			man = m_r[51:0];
		end
		if (fld >= 12'd2047)
			rnd_res = {sign_q, itf_pkg::POS_INF_BITS[62:0]};
		else
			rnd_res = {sign_q, fld[10:0], man};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (start) begin
						if (special) begin
							sum_q <= special_res;
							done_q <= 1'b1;
						end else if (x_raw == '0) begin
							sum_q <= {hi[63] & lo[63], 63'd0};
							done_q <= 1'b1;
						end else begin
							sign_q <= hi[63];
							if (x_raw[56]) begin
								x_q <= {1'b0, x_raw[56:2], x_raw[1] | x_raw[0]};
								e_q <= {1'b0, xe_hi} + 12'd1;
							end else begin
								x_q <= x_raw;
								e_q <= {1'b0, xe_hi};
							end
							state_q <= A_NORM;
						end
					end
				end
				A_NORM: begin
					if (x_q[55] || e_q <= 12'd1)
						state_q <= A_RND;
					else begin
						x_q <= x_q << k;
						e_q <= e_q - {8'd0, k};
					end
				end
				A_RND: begin
					sum_q <= rnd_res;
					done_q <= 1'b1;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign sum = sum_q;

	ast_no_done_while_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == A_NORM) |-> !done_q) else $error("adder done during normalisation");
	ast_rnd_normalised: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == A_RND) |-> (x_q[55] || e_q <= 12'd1)) else $error("rounding unnormalised");
	ast_done_after_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == A_RND) |=> done_q) else $error("rounding gave no result");

endmodule

/* src/interval_tagged_float_codec_top.sv */
`timescale 1ns / 1ps
// Interval tagged-float codec, top level.
// Uses itf_pkg and the shared binary64 adder itf_fadd.
//
// Usage: one item enters on the s_ channel (tuser selects encode or decode,
// tdata carries centre and radius); one result leaves on the m_ channel.
// s_tready is high only while the sequencer is idle; one item is handled at
// a time.
// Decode scans the low 53 bits one bit per cycle, then hands over the result.
// Encode runs trials; each trial is three additions on the single shared
// adder plus setup and compare, with at most STEP_LIMIT trials.
// The result sits in an output register. While the receiver stalls, that
// result holds; the next item is still accepted and worked on, but its
// result waits in the final state until the register frees.
// Reset empties the output register and returns the sequencer to idle.
module interval_tagged_float_codec_top #(
	parameter int STEP_LIMIT = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // center_bits [63:0], radius_bits [127:64]
	input  logic         s_tuser,   // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata    // value_bits [63:0], radius_out_bits [127:64],
	                                // status [129:128], zero fill above
);

	localparam int NW = $clog2(STEP_LIMIT + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DSCAN = 4'd1;
	localparam logic [3:0] S_ESTART = 4'd2;
	localparam logic [3:0] S_TRIAL = 4'd3;
	localparam logic [3:0] S_ADD1  = 4'd4;
	localparam logic [3:0] S_ADD2  = 4'd5;
	localparam logic [3:0] S_ADD3  = 4'd6;
	localparam logic [3:0] S_CMP   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0]  state_q;
	logic [63:0] c_q, r_q, u_q, cand_q, rb_q, lhs_q, rhs_q;
	logic        b_q, wait_q;
	logic signed [itf_pkg::PW-1:0] p_q;
	logic [NW-1:0] n_q;
	logic [52:0] sr_q;
	logic [5:0]  i_q;
	logic [63:0] res_val_q, res_rad_q;
	logic [1:0]  res_st_q;
	logic        out_v_q;
	logic [63:0] out_val_q, out_rad_q;
	logic [1:0]  out_st_q;

	logic signed [itf_pkg::EW-1:0] ec, er, pstart, rexp, uexp, dexp;

	always_comb begin
		ec = $signed({5'd0, c_q[62:52]}) - itf_pkg::EW'(itf_pkg::EXP_BIAS);
		er = $signed({5'd0, r_q[62:52]}) - itf_pkg::EW'(itf_pkg::EXP_BIAS);
		pstart = ec - er;
		if (pstart > itf_pkg::EW'(itf_pkg::FRAC_BITS))
			pstart = itf_pkg::EW'(itf_pkg::FRAC_BITS);
		uexp = ec - itf_pkg::EW'(itf_pkg::FRAC_BITS) + itf_pkg::EW'(itf_pkg::EXP_BIAS);
		rexp = ec - itf_pkg::EW'(p_q) + itf_pkg::EW'(itf_pkg::EXP_BIAS);
		dexp = $signed({5'd0, c_q[62:52]}) - itf_pkg::EW'(p_q);
	end

	// Trial candidate.
	logic [5:0]  idx;
	logic [63:0] low, cand_n;
	logic        b_n;

	always_comb begin
		idx = 6'(itf_pkg::FRAC_BITS - p_q);
		low = (64'd1 << idx) - 64'd1;
		if (p_q > 0) begin
			cand_n = (c_q & (itf_pkg::SE_MASK | (itf_pkg::MANT_MASK & ~low))) | (64'd1 << idx);
			b_n = c_q[idx] ^ c_q[63];
		end else begin
			cand_n = {c_q[63], rexp[10:0], 52'd0};
			b_n = b_q;
		end
	end

	// Shared adder.
	logic        add_go, add_done;
	logic [63:0] add_a, add_b, add_s;

	always_comb begin
		add_go = 1'b0;
		add_a = lhs_q;
		add_b = u_q;
		case (state_q)
			S_ADD1: begin
				add_go = !wait_q;
				add_a = {c_q[63] ^ !b_q, c_q[62:0]};
				add_b = r_q;
			end
			S_ADD2: add_go = !wait_q;
			S_ADD3: begin
				add_go = !wait_q;
				add_a = {cand_q[63] ^ !b_q, cand_q[62:0]};
				add_b = rb_q;
			end
			default: add_go = 1'b0;
		endcase
	end

	itf_fadd u_fadd (
		.clk(clk), .arst_n(arst_n), .start(add_go), .a(add_a), .b(add_b),
		.done(add_done), .sum(add_s)
	);

	// lhs <= rhs with NaN failing.
	logic nan_l, nan_r, le;
	logic [63:0] kl, kr;

	always_comb begin
		nan_l = (lhs_q[62:52] == 11'h7FF) && (lhs_q[51:0] != '0);
		nan_r = (rhs_q[62:52] == 11'h7FF) && (rhs_q[51:0] != '0);
		kl = lhs_q[63] ? ~lhs_q : {1'b1, lhs_q[62:0]};
		kr = rhs_q[63] ? ~rhs_q : {1'b1, rhs_q[62:0]};
		if (nan_l || nan_r)
			le = 1'b0;
		else if (lhs_q[62:0] == '0 && rhs_q[62:0] == '0)
			le = 1'b1;
		else
			le = kl <= kr;
	end

	// Decode radius and range check, evaluated once p is registered.
	logic dec_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dec_q <= 1'b0;
		else if (state_q == S_IDLE && s_tvalid)
			dec_q <= (s_tuser == itf_pkg::FUNC_DEC);
	end

	logic [63:0] fin_rad;
	logic [1:0]  fin_st;
	always_comb begin
		fin_rad = res_rad_q;
		fin_st = res_st_q;
		if (dec_q) begin
			if (dexp < 1 || dexp > 2046) begin
				fin_rad = itf_pkg::POS_INF_BITS;
				fin_st = itf_pkg::ST_RANGE;
			end else begin
				fin_rad = {1'b0, dexp[10:0], 52'd0};
				fin_st = itf_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!out_v_q || m_tready))
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						c_q <= s_tdata[63:0];
						r_q <= s_tdata[127:64];
						sr_q <= s_tdata[52:0];
						i_q <= '0;
						state_q <= (s_tuser == itf_pkg::FUNC_DEC) ? S_DSCAN : S_ESTART;
					end
				end
				S_DSCAN: begin
					if (sr_q[0] || i_q == 6'(itf_pkg::FRAC_BITS)) begin
						p_q <= sr_q[0] ? itf_pkg::PW'(itf_pkg::FRAC_BITS - i_q) : '0;
						state_q <= S_FIN;
						res_val_q <= c_q;
					end else begin
						sr_q <= sr_q >> 1;
						i_q <= i_q + 6'd1;
					end
				end
				S_ESTART: begin
					p_q <= itf_pkg::PW'(pstart);
					n_q <= '0;
					b_q <= !c_q[63];
					u_q <= {1'b0, uexp[10:0], 52'd0};
					if (uexp < 1 || uexp > 2046) begin
						res_val_q <= c_q;
						res_rad_q <= itf_pkg::POS_INF_BITS;
						res_st_q <= itf_pkg::ST_RANGE;
						state_q <= S_FIN;
					end else
						state_q <= S_TRIAL;
				end
				S_TRIAL: begin
					if (n_q == NW'(STEP_LIMIT)) begin
						res_val_q <= c_q;
						res_rad_q <= itf_pkg::POS_INF_BITS;
						res_st_q <= itf_pkg::ST_LIMIT;
						state_q <= S_FIN;
					end else if (rexp < 1 || rexp > 2046) begin
						res_val_q <= c_q;
						res_rad_q <= itf_pkg::POS_INF_BITS;
						res_st_q <= itf_pkg::ST_RANGE;
						state_q <= S_FIN;
					end else begin
						cand_q <= cand_n;
						b_q <= b_n;
						rb_q <= {1'b0, rexp[10:0], 52'd0};
						state_q <= S_ADD1;
					end
				end
				S_ADD1, S_ADD2, S_ADD3: begin
					if (add_go)
						wait_q <= 1'b1;
					if (add_done) begin
						wait_q <= 1'b0;
						if (state_q == S_ADD3) begin
							rhs_q <= add_s;
							state_q <= S_CMP;
						end else begin
							lhs_q <= add_s;
							state_q <= (state_q == S_ADD1) ? S_ADD2 : S_ADD3;
						end
					end
				end
				S_CMP: begin
					if (le) begin
						res_val_q <= cand_q;
						res_rad_q <= rb_q;
						res_st_q <= itf_pkg::ST_OK;
						state_q <= S_FIN;
					end else begin
						p_q <= p_q - 1'b1;
						n_q <= n_q + 1'b1;
						state_q <= S_TRIAL;
					end
				end
				S_FIN: begin
					if (!out_v_q || m_tready) begin
						out_val_q <= res_val_q;
						out_rad_q <= fin_rad;
						out_st_q <= fin_st;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata = {6'd0, out_st_q, out_rad_q, out_val_q};

	ast_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[129:128] != 2'd3)) else $error("invalid status code");
	ast_wait_in_add: assert property (@(posedge clk) disable iff (!arst_n)
		add_done |-> wait_q) else $error("adder result without request");
	ast_fin_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_v_q && !m_tready) |=> (state_q == S_FIN))
		else $error("result dropped while stalled");

endmodule
